### rtl/u8sd_pkg.sv
`timescale 1ns / 1ps

package u8sd_pkg;

    localparam int unsigned CP_W = 21;

    // Lead byte class boundaries.
    localparam logic [7:0] LEAD_2_MIN   = 8'hC2;
    localparam logic [7:0] LEAD_3_MIN   = 8'hE0;
    localparam logic [7:0] LEAD_4_MIN   = 8'hF0;
    localparam logic [7:0] LEAD_BAD_MIN = 8'hF8;

    // Continuation bytes carry the pattern 10xxxxxx.
    localparam logic [1:0] CONT_TAG  = 2'b10;
    localparam logic [7:0] CONT_MASK = 8'h3F;

    // Payload masks for the lead bytes.
    localparam logic [7:0] LEAD_2_MASK = 8'h1F;
    localparam logic [7:0] LEAD_3_MASK = 8'h0F;
    localparam logic [7:0] LEAD_4_MASK = 8'h07;

    // Second byte bits that rule out overlong forms.
    localparam logic [7:0] E0_SECOND_BITS = 8'h20;
    localparam logic [7:0] F0_SECOND_BITS = 8'h30;

    // Pending check on the byte after an E0 or F0 lead.
    typedef enum logic [1:0] {
        RULE_NONE = 2'd0,
        RULE_E0   = 2'd1,
        RULE_F0   = 2'd2
    } rule_t;

    typedef struct packed {
        logic            emit;
        logic [CP_W-1:0] code_point;
        logic            status;
        logic            last;
    } result_t;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

endpackage

### rtl/u8sd_decode.sv
`timescale 1ns / 1ps

module u8sd_decode
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        byte_in,
    input  logic              end_of_string,
    output u8sd_pkg::result_t res
);
    import u8sd_pkg::*;

    logic [CP_W-1:0] partial_reg;
    logic [CP_W-1:0] partial_next;
    logic [1:0]      remain_reg;
    logic [1:0]      remain_next;
    rule_t           rule_reg;
    rule_t           rule_next;
    logic            discard_reg;
    logic            discard_next;

    always_comb
    begin
        logic       fail;
        logic       cont_bad;
        logic [1:0] remain_dec;

        partial_next = partial_reg;
        remain_next  = remain_reg;
        rule_next    = rule_reg;
        discard_next = discard_reg;
        res          = '0;
        fail         = 1'b0;
        remain_dec   = remain_reg - 2'd1;
        cont_bad     = (byte_in[7:6] != CONT_TAG)
                    || (rule_reg == RULE_E0 && (byte_in & E0_SECOND_BITS) == 8'h00)
                    || (rule_reg == RULE_F0 && (byte_in & F0_SECOND_BITS) == 8'h00);

        if (step)
        begin
            if (discard_reg)
            begin
                if (end_of_string)
                begin
                    discard_next = 1'b0;
                end
            end
            else if (remain_reg == 2'd0)
            begin
                if (!byte_in[7])
                begin
                    res.emit       = 1'b1;
                    res.code_point = {{(CP_W-8){1'b0}}, byte_in};
                    res.status     = STATUS_OK;
                    res.last       = end_of_string;
                end
                else if (byte_in >= LEAD_2_MIN && byte_in < LEAD_3_MIN)
                begin
                    partial_next = {{(CP_W-8){1'b0}}, byte_in & LEAD_2_MASK};
                    remain_next  = 2'd1;
                    rule_next    = RULE_NONE;
                    fail         = end_of_string;
                end
                else if (byte_in >= LEAD_3_MIN && byte_in < LEAD_4_MIN)
                begin
                    partial_next = {{(CP_W-8){1'b0}}, byte_in & LEAD_3_MASK};
                    remain_next  = 2'd2;
                    rule_next    = (byte_in == LEAD_3_MIN) ? RULE_E0 : RULE_NONE;
                    fail         = end_of_string;
                end
                else if (byte_in >= LEAD_4_MIN && byte_in < LEAD_BAD_MIN)
                begin
                    partial_next = {{(CP_W-8){1'b0}}, byte_in & LEAD_4_MASK};
                    remain_next  = 2'd3;
                    rule_next    = (byte_in == LEAD_4_MIN) ? RULE_F0 : RULE_NONE;
                    fail         = end_of_string;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            else if (cont_bad)
            begin
                fail = 1'b1;
            end
            else
            begin
                partial_next = {partial_reg[CP_W-7:0], byte_in[5:0] & CONT_MASK[5:0]};
                remain_next  = remain_dec;
                rule_next    = RULE_NONE;
                if (remain_dec == 2'd0)
                begin
                    res.emit       = 1'b1;
                    res.code_point = partial_next;
                    res.status     = STATUS_OK;
                    res.last       = end_of_string;
                    partial_next   = '0;
                end
                else
                begin
                    fail = end_of_string;
                end
            end

            if (fail)
            begin
                partial_next   = '0;
                remain_next    = 2'd0;
                rule_next      = RULE_NONE;
                discard_next   = !end_of_string;
                res.emit       = 1'b1;
                res.code_point = '0;
                res.status     = STATUS_ERR;
                res.last       = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            remain_reg  <= 2'd0;
            rule_reg    <= RULE_NONE;
            discard_reg <= 1'b0;
        end
        else
        begin
            partial_reg <= partial_next;
            remain_reg  <= remain_next;
            rule_reg    <= rule_next;
            discard_reg <= discard_next;
        end
    end

    // While dropping bytes no sequence may be open.
    a_discard_idle: assert property (@(posedge clk) disable iff (!rst_n)
        discard_reg |-> (remain_reg == 2'd0 && rule_reg == RULE_NONE))
        else $error("sequence open while discarding");

    // An overlong check is only pending right after a 3- or 4-byte lead.
    a_rule_remain: assert property (@(posedge clk) disable iff (!rst_n)
        (rule_reg != RULE_NONE) |-> (remain_reg == 2'd2 || remain_reg == 2'd3))
        else $error("overlong check pending with wrong byte count");

    // Every error result is zero-valued and closes the string.
    a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
        (res.emit && res.status == STATUS_ERR) |-> (res.last && res.code_point == '0))
        else $error("malformed error result");

    // Nothing is emitted while dropping bytes.
    a_discard_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        discard_reg |-> !res.emit)
        else $error("result emitted while discarding");

endmodule

### rtl/utf8_stream_decoder_core.sv
`timescale 1ns / 1ps

// UTF-8 stream decoder. Each input word is one byte of a string plus an
// end_of_string flag; each output word is one decoded code point with a status
// bit and a last flag. The core sustains one byte per clock cycle: a byte is
// held in an input register, decoded by a single level of masking, shifting and
// comparing logic together with the sequence state, and the result is captured
// in an output register. Back-pressure from out_ready stalls the input only when
// the output register is full and not being drained. A byte that completes a
// character gives one result; lead and middle bytes of a multi-byte sequence
// give none.
// Leads 00-7F, C2-DF, E0-EF and F0-F7 are accepted; overlong 3- and 4-byte
// forms are rejected, while surrogates and values up to 1FFFFF are passed.
// Any malformed byte, or a string ending inside a sequence, yields one error
// result (code_point zero, status one, last one), after which bytes are
// dropped silently up to and including the string's final byte.

module utf8_stream_decoder_core
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                byte_in,
    input  logic                      end_of_string,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [u8sd_pkg::CP_W-1:0] code_point,
    output logic                      status,
    output logic                      last
);
    import u8sd_pkg::*;

    // Input register stage.
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] byte_reg;
    logic       eos_reg;

    // Output register stage.
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [CP_W-1:0] cp_reg;
    logic            status_reg;
    logic            last_reg;

    logic    advance;
    result_t res;

    // The held byte moves through the decoder whenever the result register is
    // free or is being emptied in this same cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = res.emit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    u8sd_decode u_decode
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .byte_in       (byte_reg),
        .end_of_string (eos_reg),
        .res           (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= byte_in;
            eos_reg  <= end_of_string;
        end
        if (advance && res.emit)
        begin
            cp_reg     <= res.code_point;
            status_reg <= res.status;
            last_reg   <= res.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign code_point = cp_reg;
    assign status     = status_reg;
    assign last       = last_reg;

    // A held byte that cannot advance must still be held next cycle.
    a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input byte lost while stalled");

endmodule
